// ----- design/rmb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmb_pkg
// Shared types and constants of the modal resonator bank step unit.
// ----------------------------------------------------------------------------
package rmb_pkg;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] CFG_INV_STEP    = 2'd0;
  localparam logic [1:0] CFG_INV_STEP_SQ = 2'd1;

  localparam logic [23:0] INV_STEP_RESET    = 24'd44100;
  localparam logic [47:0] INV_STEP_SQ_RESET = 48'd1944810000;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_STEP,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic        [7:0]  mode;
    logic signed [31:0] cn;
    logic signed [31:0] co;
    logic signed [31:0] cf;
    logic signed [31:0] force_in;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage
`default_nettype wire

// ----- design/rmb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmb_front
// Accepts commands, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module rmb_front import rmb_pkg::*; #(
  parameter int MODE_COUNT = 256
) (
  input  wire logic               start,
  input  wire logic        [1:0]  req_type,
  input  wire logic        [7:0]  mode_index,
  input  wire logic signed [31:0] coeff_new,
  input  wire logic signed [31:0] coeff_old,
  input  wire logic signed [31:0] coeff_force,
  input  wire logic signed [31:0] modal_force,
  input  wire logic               q_full,
  input  wire back_stat_t         stat,
  output logic                    busy,
  output logic                    push,
  output item_t                   push_item
);

  logic in_range;

  assign in_range = {5'd0, mode_index} < 13'(MODE_COUNT);
  assign busy     = q_full | stat.clearing;
  assign push     = start & ~busy;

  always_comb begin
    push_item.mode     = mode_index;
    push_item.cn       = coeff_new;
    push_item.co       = coeff_old;
    push_item.cf       = coeff_force;
    push_item.force_in = modal_force;
    push_item.op       = OP_NOP;
    if (in_range) begin
      case (req_type)
        REQ_LOAD:  push_item.op = OP_LOAD;
        REQ_STEP:  push_item.op = OP_STEP;
        REQ_CLEAR: push_item.op = OP_CLEAR;
        default:   push_item.op = OP_NOP;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/rmb_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmb_queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module rmb_queue import rmb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output logic       full,
  output logic       empty
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = slots[rd_ptr];
  assign full  = count == 2'd2;
  assign empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/rmb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmb_back
// Executes commands against the history and coefficient memories.
// ----------------------------------------------------------------------------
module rmb_back import rmb_pkg::*; #(
  parameter int MODE_COUNT = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic        [23:0] inv_step,
  input  wire logic        [47:0] inv_step_squared,
  input  wire item_t              q_item,
  input  wire logic               q_empty,
  output logic                    pop,
  output back_stat_t              stat,
  output logic                    done,
  output logic             [7:0]  echo_mode,
  output logic signed      [31:0] next_displacement,
  output logic signed      [47:0] velocity_behind,
  output logic signed      [47:0] accel_now,
  output logic signed      [47:0] accel_half_ahead,
  output logic                    saturated
);

  localparam int DEPTH = (MODE_COUNT > 256) ? 256 : MODE_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EXEC, S_MUL, S_SUM, S_SATN, S_DIFF, S_SCALE, S_CHK, S_DONE
  } state_t;

  state_t             state;
  item_t              it;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      addr;
  logic [1:0]         cnt;
  logic [1:0]         sel;
  logic [1:0]         part;

  logic [95:0]        hist_mem [DEPTH];
  logic [95:0]        coef_mem [DEPTH];
  logic [95:0]        hist_rd;
  logic [95:0]        coef_rd;
  logic               hist_we;
  logic [AW-1:0]      hist_wa;
  logic [95:0]        hist_wd;
  logic               coef_we;
  logic               mem_re;

  logic signed [31:0] qp, qc, qn;
  logic signed [63:0] prod;
  logic signed [65:0] acc;
  logic signed [65:0] rnd;
  logic signed [31:0] nn;
  logic               sat;
  logic [35:0]        mag_v, mag_a, mag_h;
  logic               neg_v, neg_a, neg_h;
  logic [83:0]        sacc;

  logic signed [35:0] dv, d1, d2, dh;
  logic [35:0]        cur_mag;
  logic               cur_neg;
  logic [47:0]        cur_k;
  logic [17:0]        mpart;
  logic [23:0]        kpart;
  logic [6:0]         shamt;
  logic [41:0]        pp;
  logic [83:0]        scaled;
  logic               ssat;
  logic signed [47:0] sval;

  assign addr = it.mode[AW-1:0];
  assign qp   = hist_rd[95:64];
  assign qc   = hist_rd[63:32];
  assign qn   = hist_rd[31:0];
  assign pop  = (state == S_IDLE) && !q_empty;
  assign stat.clearing = state == S_CLR;

  always_comb begin
    hist_we = (state == S_CLR) || (state == S_DONE) ||
              ((state == S_EXEC) && (it.op == OP_CLEAR));
    hist_wa = (state == S_CLR) ? clr_addr : addr;
    hist_wd = (state == S_DONE) ? {qc, qn, nn} : 96'd0;
    coef_we = (state == S_EXEC) && (it.op == OP_LOAD);
    mem_re  = (state == S_EXEC) && (it.op == OP_STEP);
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (coef_we) begin
      coef_mem[addr] <= {it.cn, it.co, it.cf};
    end
    if (mem_re) begin
      hist_rd <= hist_mem[addr];
      coef_rd <= coef_mem[addr];
    end
  end

  always_comb begin
    rnd = acc + 66'sd536870912;
    rnd = rnd >>> 30;
    dv  = 36'(qc) - 36'(qp);
    d1  = 36'(qn) + 36'(qp) - (36'(qc) <<< 1);
    d2  = 36'(nn) + 36'(qc) - (36'(qn) <<< 1);
    dh  = d1 + d2;
    case (sel)
      2'd0: begin
        cur_mag = mag_v;
        cur_neg = neg_v;
        cur_k   = {24'd0, inv_step};
      end
      2'd1: begin
        cur_mag = mag_a;
        cur_neg = neg_a;
        cur_k   = inv_step_squared;
      end
      default: begin
        cur_mag = mag_h;
        cur_neg = neg_h;
        cur_k   = inv_step_squared;
      end
    endcase
    mpart  = part[0] ? cur_mag[35:18] : cur_mag[17:0];
    kpart  = part[1] ? cur_k[47:24] : cur_k[23:0];
    shamt  = (part[0] ? 7'd18 : 7'd0) + (part[1] ? 7'd24 : 7'd0);
    pp     = {24'd0, mpart} * {18'd0, kpart};
    scaled = sacc;
    if (sel == 2'd2) begin
      scaled = cur_neg ? ((sacc + 84'd1) >> 1) : (sacc >> 1);
    end
    ssat = cur_neg ? (scaled > 84'h800000000000) : (scaled > 84'h7FFFFFFFFFFF);
    if (ssat) begin
      sval = cur_neg ? 48'sh800000000000 : 48'sh7FFFFFFFFFFF;
    end else begin
      sval = cur_neg ? -$signed(scaled[47:0]) : $signed(scaled[47:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            it    <= q_item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (it.op == OP_STEP) begin
            cnt   <= 2'd0;
            sat   <= 1'b0;
            state <= S_MUL;
          end else begin
            done              <= 1'b1;
            echo_mode         <= it.mode;
            next_displacement <= '0;
            velocity_behind   <= '0;
            accel_now         <= '0;
            accel_half_ahead  <= '0;
            saturated         <= 1'b0;
            state             <= S_IDLE;
          end
        end
        S_MUL: begin
          cnt <= cnt + 2'd1;
          case (cnt)
            2'd0: prod <= $signed(coef_rd[95:64]) * qn;
            2'd1: begin
              acc  <= 66'(prod);
              prod <= $signed(coef_rd[63:32]) * qc;
            end
            default: begin
              acc   <= acc + 66'(prod);
              prod  <= $signed(coef_rd[31:0]) * it.force_in;
              state <= S_SUM;
            end
          endcase
        end
        S_SUM: begin
          acc   <= acc + 66'(prod);
          state <= S_SATN;
        end
        S_SATN: begin
          if (rnd > 66'sh7FFFFFFF) begin
            nn  <= 32'sh7FFFFFFF;
            sat <= 1'b1;
          end else if (rnd < -66'sh80000000) begin
            nn  <= 32'sh80000000;
            sat <= 1'b1;
          end else begin
            nn <= rnd[31:0];
          end
          state <= S_DIFF;
        end
        S_DIFF: begin
          neg_v <= dv[35];
          neg_a <= d1[35];
          neg_h <= dh[35];
          mag_v <= dv[35] ? 36'(-dv) : 36'(dv);
          mag_a <= d1[35] ? 36'(-d1) : 36'(d1);
          mag_h <= dh[35] ? 36'(-dh) : 36'(dh);
          sel   <= 2'd0;
          part  <= 2'd0;
          sacc  <= '0;
          state <= S_SCALE;
        end
        S_SCALE: begin
          sacc <= sacc + (84'(pp) << shamt);
          part <= part + 2'd1;
          if (part == 2'd3) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (ssat) begin
            sat <= 1'b1;
          end
          case (sel)
            2'd0:    velocity_behind <= sval;
            2'd1:    accel_now <= sval;
            default: accel_half_ahead <= sval;
          endcase
          sacc <= '0;
          part <= 2'd0;
          sel  <= sel + 2'd1;
          state <= (sel == 2'd2) ? S_DONE : S_SCALE;
        end
        S_DONE: begin
          done              <= 1'b1;
          echo_mode         <= it.mode;
          next_displacement <= nn;
          saturated         <= sat;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/modal_resonator_bank_step_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modal_resonator_bank_step_unit
// Bank of two-pole modal resonators with per-mode history and coefficients.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Every command gives
// one result, shown for one cycle with done high; the receiver cannot stall.
// A step command goes through the back unit in turn: queue pop, memory read,
// three shared 32x32 multiplies with accumulate, rounding, differences, and
// three scalings of four 18x24 partial products each, then history writeback.
// Load, clear and ignored commands need only pop and execute. A two-entry
// queue lets the next commands transfer while one executes. After reset the
// history memory is cleared one mode per cycle, min(MODE_COUNT,256) modes with
// busy high; configuration writes are taken at any time (cfg_ready tied high).
module modal_resonator_bank_step_unit import rmb_pkg::*; #(
  parameter int MODE_COUNT = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [1:0]  req_type,
  input  wire logic        [7:0]  mode_index,
  input  wire logic signed [31:0] coeff_new,
  input  wire logic signed [31:0] coeff_old,
  input  wire logic signed [31:0] coeff_force,
  input  wire logic signed [31:0] modal_force,
  output logic                    done,
  output logic             [7:0]  echo_mode,
  output logic signed      [31:0] next_displacement,
  output logic signed      [47:0] velocity_behind,
  output logic signed      [47:0] accel_now,
  output logic signed      [47:0] accel_half_ahead,
  output logic                    saturated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [1:0]  cfg_index,
  input  wire logic        [47:0] cfg_data
);

  logic [23:0] inv_step;
  logic [47:0] inv_step_squared;
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  item_t       push_item;
  item_t       head;
  back_stat_t  stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_step         <= INV_STEP_RESET;
      inv_step_squared <= INV_STEP_SQ_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INV_STEP:    inv_step <= cfg_data[23:0];
        CFG_INV_STEP_SQ: inv_step_squared <= cfg_data;
        default: ;
      endcase
    end
  end

  rmb_front #(.MODE_COUNT(MODE_COUNT)) u_front (
    .start       (start),
    .req_type    (req_type),
    .mode_index  (mode_index),
    .coeff_new   (coeff_new),
    .coeff_old   (coeff_old),
    .coeff_force (coeff_force),
    .modal_force (modal_force),
    .q_full      (q_full),
    .stat        (stat),
    .busy        (busy),
    .push        (push),
    .push_item   (push_item)
  );

  rmb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  rmb_back #(.MODE_COUNT(MODE_COUNT)) u_back (
    .clk               (clk),
    .rst               (rst),
    .inv_step          (inv_step),
    .inv_step_squared  (inv_step_squared),
    .q_item            (head),
    .q_empty           (q_empty),
    .pop               (pop),
    .stat              (stat),
    .done              (done),
    .echo_mode         (echo_mode),
    .next_displacement (next_displacement),
    .velocity_behind   (velocity_behind),
    .accel_now         (accel_now),
    .accel_half_ahead  (accel_half_ahead),
    .saturated         (saturated)
  );

endmodule
`default_nettype wire
